### rtl/core/fan_curve_hysteresis_controller_macros.svh
// Assertion macros shared by the fan curve hysteresis controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FAN_CURVE_HYSTERESIS_CONTROLLER_MACROS_SVH
`define FAN_CURVE_HYSTERESIS_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define FCHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define FCHC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FCHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCHC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/core/fchc_pkg.sv
// Package of the fan curve hysteresis controller: sizes, codes, state types.
// No dependencies; used by fchc_update, the top level and the testbench.
`timescale 1ns / 1ps

package fchc_pkg;

  localparam int FAN_COUNT  = 4;
  localparam int TEMP_STEPS = 256;

  localparam int FAN_AW    = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;
  localparam int TIDX_W    = $clog2(TEMP_STEPS);
  localparam int TBL_DEPTH = FAN_COUNT * TEMP_STEPS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam logic [7:0]  TEMP_RESET_MIN = 8'hFF;
  localparam logic [15:0] ERR_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_START     = 2'd1,
    CMD_LOAD_RISE = 2'd2,
    CMD_LOAD_FALL = 2'd3
  } cmd_t;

  // Per-fan record held in the fan state memory.
  typedef struct packed {
    logic [7:0]  last_temp;
    logic [7:0]  last_duty;
    logic [7:0]  min_seen;
    logic [7:0]  max_seen;
    logic [15:0] error_count;
  } fan_state_t;

  localparam int FAN_STATE_W = $bits(fan_state_t);

  localparam fan_state_t FAN_STATE_RESET = '{
    last_temp:   8'h00,
    last_duty:   8'h00,
    min_seen:    TEMP_RESET_MIN,
    max_seen:    8'h00,
    error_count: 16'h0000
  };

  // Sample fields that the update logic needs.
  typedef struct packed {
    cmd_t       command;
    logic       sensor_ok;
    logic [7:0] temperature;
  } sample_t;

  // Duty programming decision of one transaction.
  typedef struct packed {
    logic       duty_write;
    logic [7:0] duty;
  } duty_cmd_t;

  function automatic logic fan_in_range(input logic [1:0] fan);
    return 32'(fan) < FAN_COUNT;
  endfunction

  function automatic logic temp_in_range(input logic [7:0] temp);
    return 32'(temp) < TEMP_STEPS;
  endfunction

  // Curve table address; samples beyond the table use the last entry.
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [FAN_AW-1:0] fan_idx,
                                                 input logic [7:0] temp);
    logic [TIDX_W-1:0] tidx;
    tidx = temp_in_range(temp) ? TIDX_W'(temp) : TIDX_W'(TEMP_STEPS - 1);
    return TBL_AW'(TBL_AW'(fan_idx) * TBL_AW'(TEMP_STEPS)) + TBL_AW'(tidx);
  endfunction

endpackage

### rtl/core/fchc_ifs.sv
// Channel interfaces of the fan curve hysteresis controller.
// Depends on nothing; the payload widths follow the item fields.
`timescale 1ns / 1ps

interface fchc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] fan;
  logic       sensor_ok;
  logic [7:0] temperature;
  logic [7:0] entry_value;
  modport source (output valid, command, fan, sensor_ok, temperature, entry_value,
                  input ready);
  modport sink   (input valid, command, fan, sensor_ok, temperature, entry_value,
                  output ready);
endinterface

interface fchc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fan_out;
  logic        duty_write;
  logic [7:0]  duty;
  logic [7:0]  current_level;
  logic [7:0]  min_temp;
  logic [7:0]  max_temp;
  logic [15:0] error_total;
  modport source (output valid, fan_out, duty_write, duty, current_level, min_temp,
                  max_temp, error_total, input ready);
  modport sink   (input valid, fan_out, duty_write, duty, current_level, min_temp,
                  max_temp, error_total, output ready);
endinterface

interface fchc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/fchc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; the read data holds while no read is enabled.
`timescale 1ns / 1ps

module fchc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/fchc_update.sv
// Hysteresis update of one fan record for a sample or start transaction.
// Depends on fchc_pkg; pure combinational logic between RAM read and write back.
`timescale 1ns / 1ps

module fchc_update (
  input  fchc_pkg::sample_t    sample,
  input  fchc_pkg::fan_state_t state_cur,
  input  logic [7:0]           rise_entry,
  input  logic [7:0]           fall_entry,
  input  logic [7:0]           max_duty,
  output fchc_pkg::fan_state_t state_nxt,
  output fchc_pkg::duty_cmd_t  duty_cmd
);

  fchc_pkg::fan_state_t st;
  logic [7:0] temp;

  assign temp = sample.temperature;

  always_comb begin
    st       = state_cur;
    duty_cmd = '0;
    case (sample.command)
      fchc_pkg::CMD_SAMPLE, fchc_pkg::CMD_START: begin
        if (sample.command == fchc_pkg::CMD_START) begin
          st = fchc_pkg::FAN_STATE_RESET;
        end
        if (!sample.sensor_ok) begin
          duty_cmd.duty_write = 1'b1;
          duty_cmd.duty       = max_duty;
          st.last_temp        = 8'h00;
          if (st.error_count != fchc_pkg::ERR_MAX) begin
            st.error_count = st.error_count + 16'd1;
          end
        end else if (temp != st.last_temp) begin
          if (temp > st.last_temp) begin
            // A zero rise entry while the last temperature is zero falls back on the fall curve.
            if (rise_entry == 8'h00 && st.last_temp == 8'h00) begin
              duty_cmd.duty_write = 1'b1;
              duty_cmd.duty       = fall_entry;
              st.last_duty        = fall_entry;
            end else if (rise_entry > st.last_duty) begin
              duty_cmd.duty_write = 1'b1;
              duty_cmd.duty       = rise_entry;
              st.last_duty        = rise_entry;
            end
          end else if (fall_entry < st.last_duty) begin
            duty_cmd.duty_write = 1'b1;
            duty_cmd.duty       = fall_entry;
            st.last_duty        = fall_entry;
          end
          st.last_temp = temp;
          if (temp > st.max_seen) begin
            st.max_seen = temp;
          end
          if (temp < st.min_seen) begin
            st.min_seen = temp;
          end
        end
      end
      default: begin
        st = state_cur;
      end
    endcase
    state_nxt = st;
  end

endmodule

### rtl/core/fan_curve_hysteresis_controller.sv
// Top level of the fan curve hysteresis controller: pipeline, memories, output.
// Depends on fchc_pkg, fchc_ifs, fchc_ram, fchc_update and the macros header.
`timescale 1ns / 1ps

// Usage:
// The in_ch channel carries one transaction per command: a sample, a start followed
// by a sample, or a load of one rise or fall curve entry for the addressed fan.
// Every accepted transaction produces exactly one transaction on out_ch, in order,
// holding the duty decision and the fan record after the command.
// The cfg_ch channel writes max_duty, the duty forced on a sensor failure; it is
// always ready and should only be written while the block is idle.
// A transaction accepted into stage 1 reads the curve tables and the fan state
// memory; its result is then registered in the output register. Throughput is one
// transaction per cycle unless out_ch stalls. The fan state memory is read at
// accept and written back as stage 1 advances; a back-to-back transaction for the
// same fan takes the written record from a forwarding register, not the memory.
// Curve loads write the table memories at accept, so a later sample sees them.
// When out_ch stalls, the output register holds its result, the stage behind it
// keeps its transaction and the memory read data, and in_ch ready drops only when
// both are occupied.
// Reset clears the per-fan valid bits, so every fan record reads as its reset value
// at once, and sets max_duty to 255. The curve tables are undefined until loaded
// and get no clearing pass.

`include "fan_curve_hysteresis_controller_macros.svh"

module fan_curve_hysteresis_controller (
  input  logic         clk,
  input  logic         rst_n,
  fchc_in_if.sink      in_ch,
  fchc_out_if.source   out_ch,
  fchc_cfg_if.sink     cfg_ch
);

  // Configuration register.
  logic [7:0] max_duty_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_duty_r <= 8'hFF;
    end else if (cfg_ch.valid) begin
      max_duty_r <= cfg_ch.data;
    end
  end

  // Handshake and decode of the incoming transaction.
  logic                        in_acc;
  logic                        s1_adv;
  fchc_pkg::cmd_t              in_cmd;
  logic                        in_fan_ok;
  logic [fchc_pkg::FAN_AW-1:0] in_fan_idx;
  logic                        in_is_load;
  logic [fchc_pkg::TBL_AW-1:0] in_tbl_addr;
  logic                        tbl_we_ok;

  assign in_cmd      = fchc_pkg::cmd_t'(in_ch.command);
  assign in_fan_ok   = fchc_pkg::fan_in_range(in_ch.fan);
  assign in_fan_idx  = fchc_pkg::FAN_AW'(in_ch.fan);
  assign in_is_load  = in_cmd inside {fchc_pkg::CMD_LOAD_RISE, fchc_pkg::CMD_LOAD_FALL};
  assign in_tbl_addr = fchc_pkg::tbl_addr(in_fan_idx, in_ch.temperature);
  assign tbl_we_ok   = in_acc && in_is_load && in_fan_ok &&
                       fchc_pkg::temp_in_range(in_ch.temperature);

  // Stage 1 registers: the transaction whose memory reads are in flight.
  logic                        s1_vld_r, s1_vld_nxt;
  fchc_pkg::sample_t           s1_sample_r;
  logic [1:0]                  s1_fan_r;
  logic                        s1_fan_ok_r;
  logic [fchc_pkg::FAN_AW-1:0] s1_fan_idx_r;
  logic                        s1_st_vld_r;
  logic                        fwd_r, fwd_nxt;
  fchc_pkg::fan_state_t        fwd_st_r;

  logic                        out_vld_r, out_vld_nxt;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Curve tables, one entry per fan and temperature step.
  logic [7:0] rise_q;
  logic [7:0] fall_q;

  fchc_ram #(
    .WIDTH (8),
    .DEPTH (fchc_pkg::TBL_DEPTH)
  ) u_rise_ram (
    .clk   (clk),
    .we    (tbl_we_ok && in_cmd == fchc_pkg::CMD_LOAD_RISE),
    .waddr (in_tbl_addr),
    .wdata (in_ch.entry_value),
    .re    (in_acc),
    .raddr (in_tbl_addr),
    .rdata (rise_q)
  );

  fchc_ram #(
    .WIDTH (8),
    .DEPTH (fchc_pkg::TBL_DEPTH)
  ) u_fall_ram (
    .clk   (clk),
    .we    (tbl_we_ok && in_cmd == fchc_pkg::CMD_LOAD_FALL),
    .waddr (in_tbl_addr),
    .wdata (in_ch.entry_value),
    .re    (in_acc),
    .raddr (in_tbl_addr),
    .rdata (fall_q)
  );

  // Fan state memory with one valid bit per fan.
  fchc_pkg::fan_state_t st_q;
  fchc_pkg::fan_state_t st_cur;
  fchc_pkg::fan_state_t st_upd;
  fchc_pkg::duty_cmd_t  duty_cmd;
  logic                 st_we;
  logic [fchc_pkg::FAN_COUNT-1:0] st_vld_r, st_vld_nxt;

  assign st_we = s1_adv && s1_fan_ok_r;

  fchc_ram #(
    .WIDTH (fchc_pkg::FAN_STATE_W),
    .DEPTH (fchc_pkg::FAN_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (s1_fan_idx_r),
    .wdata (st_upd),
    .re    (in_acc),
    .raddr (in_fan_idx),
    .rdata (st_q)
  );

  // The newest copy of the record: forwarded, stored, or the reset value.
  always_comb begin
    if (fwd_r) begin
      st_cur = fwd_st_r;
    end else if (s1_st_vld_r) begin
      st_cur = st_q;
    end else begin
      st_cur = fchc_pkg::FAN_STATE_RESET;
    end
  end

  fchc_update u_update (
    .sample     (s1_sample_r),
    .state_cur  (st_cur),
    .rise_entry (rise_q),
    .fall_entry (fall_q),
    .max_duty   (max_duty_r),
    .state_nxt  (st_upd),
    .duty_cmd   (duty_cmd)
  );

  always_comb begin
    st_vld_nxt = st_vld_r;
    if (st_we) begin
      st_vld_nxt[s1_fan_idx_r] = 1'b1;
    end
  end

  // A transaction for the fan being written back in the same cycle must not use
  // the stale memory word. The flag drops once stage 1 empties.
  assign fwd_nxt = in_acc ? (st_we && s1_fan_idx_r == in_fan_idx) : (fwd_r && !s1_adv);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_r     <= 1'b0;
      out_vld_r <= 1'b0;
      st_vld_r  <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      fwd_r     <= fwd_nxt;
      out_vld_r <= out_vld_nxt;
      st_vld_r  <= st_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r.command     <= in_cmd;
      s1_sample_r.sensor_ok   <= in_ch.sensor_ok;
      s1_sample_r.temperature <= in_ch.temperature;
      s1_fan_r                <= in_ch.fan;
      s1_fan_ok_r             <= in_fan_ok;
      s1_fan_idx_r            <= in_fan_idx;
      s1_st_vld_r             <= st_vld_r[in_fan_idx];
      fwd_st_r                <= st_upd;
    end
  end

  // Output register; a fan outside the configured range reports zeros.
  logic [1:0]  out_fan_r;
  logic        out_wr_r;
  logic [7:0]  out_duty_r;
  logic [7:0]  out_level_r;
  logic [7:0]  out_min_r;
  logic [7:0]  out_max_r;
  logic [15:0] out_err_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_fan_r <= s1_fan_r;
      if (s1_fan_ok_r) begin
        out_wr_r    <= duty_cmd.duty_write;
        out_duty_r  <= duty_cmd.duty;
        out_level_r <= st_upd.last_duty;
        out_min_r   <= st_upd.min_seen;
        out_max_r   <= st_upd.max_seen;
        out_err_r   <= st_upd.error_count;
      end else begin
        out_wr_r    <= 1'b0;
        out_duty_r  <= 8'h00;
        out_level_r <= 8'h00;
        out_min_r   <= 8'h00;
        out_max_r   <= 8'h00;
        out_err_r   <= 16'h0000;
      end
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.fan_out       = out_fan_r;
  assign out_ch.duty_write    = out_wr_r;
  assign out_ch.duty          = out_duty_r;
  assign out_ch.current_level = out_level_r;
  assign out_ch.min_temp      = out_min_r;
  assign out_ch.max_temp      = out_max_r;
  assign out_ch.error_total   = out_err_r;

  // A stalled stage 1 must block new transactions, or its memory data is lost.
  `FCHC_ASSERT_NEVER(a_no_accept_on_stall, clk, rst_n, s1_vld_r && !s1_adv && in_acc,
    "transaction accepted while stage 1 is stalled")
  // Forwarded data only ever belongs to a transaction in stage 1.
  `FCHC_ASSERT(a_fwd_needs_s1, clk, rst_n, fwd_r |-> s1_vld_r,
    "forwarding flag set without a stage 1 transaction")
  // Write-back and read of the same fan in one cycle must select forwarding.
  `FCHC_ASSERT(a_fwd_on_same_fan, clk, rst_n,
    (in_acc && st_we && s1_fan_idx_r == in_fan_idx) |=> fwd_r,
    "same-fan write back not forwarded")
  // A new result only appears after stage 1 held a transaction.
  `FCHC_ASSERT(a_out_from_s1, clk, rst_n, $rose(out_vld_r) |-> $past(s1_vld_r),
    "output valid without a stage 1 transaction")
  // Diverted fans never leave a record write behind.
  `FCHC_ASSERT_NEVER(a_no_write_bad_fan, clk, rst_n, st_we && !s1_fan_ok_r,
    "fan state written for a fan out of range")

endmodule

### dv/tb_fan_curve_hysteresis_controller.sv
// Self-checking testbench for fan_curve_hysteresis_controller: a directed script, then random
// fan traffic under several flow-control mixes, checked against a built-in predictor or typed rows.
// Depends on fchc_pkg and the channel interfaces in fchc_ifs.
`timescale 1ns / 1ps

module tb_fan_curve_hysteresis_controller;
  import fchc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS_PER_PHASE = 405;

  // Percentages of cycles in which the sender idles and the receiver stalls, per phase:
  // no idling, sender idle, receiver stalling, and both together.
  localparam int SRC_IDLE_PCT [4] = '{0, 75, 0, 20};
  localparam int SNK_STALL_PCT [4] = '{0, 0, 75, 20};

  // One command transaction as it appears on in_ch.
  typedef struct packed {
    cmd_t       command;
    logic [1:0] fan;
    logic       sensor_ok;
    logic [7:0] temperature;
    logic [7:0] entry_value;
  } fan_cmd_t;

  // One result transaction as it appears on out_ch.
  typedef struct packed {
    logic [1:0]  fan_out;
    logic        duty_write;
    logic [7:0]  duty;
    logic [7:0]  current_level;
    logic [7:0]  min_temp;
    logic [7:0]  max_temp;
    logic [15:0] error_total;
  } fan_report_t;

  // A directed step. When typed is set, the report written next to the command is the
  // expected result; otherwise the predictor supplies it.
  typedef struct packed {
    fan_cmd_t    op;
    logic        typed;
    fan_report_t report;
  } script_row_t;

  localparam fan_report_t PREDICTED = '0;

  // The directed script. It opens on fresh reset state, where the expected records can be
  // read straight off the reset values, then walks one fan around the hysteresis loop.
  localparam script_row_t SCRIPT [27] = '{
    // Sensor failure on a fresh fan: maximum duty forced, one error counted.
    '{'{CMD_SAMPLE, 2'd0, 1'b0, 8'h5A, 8'h00}, 1'b1,
      '{2'd0, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'd1}},
    // Loads at the table extremes only report the untouched fan record.
    '{'{CMD_LOAD_RISE, 2'd2, 1'b1, 8'hFF, 8'hFF}, 1'b1,
      '{2'd2, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 16'd0}},
    '{'{CMD_LOAD_FALL, 2'd2, 1'b0, 8'hFF, 8'h80}, 1'b1,
      '{2'd2, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 16'd0}},
    '{'{CMD_LOAD_RISE, 2'd3, 1'b1, 8'h00, 8'h00}, 1'b1,
      '{2'd3, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 16'd0}},
    '{'{CMD_LOAD_FALL, 2'd3, 1'b1, 8'h00, 8'hA5}, 1'b1,
      '{2'd3, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 16'd0}},
    // A sample equal to the last temperature (zero after reset) changes nothing,
    // not even the minimum seen.
    '{'{CMD_SAMPLE, 2'd3, 1'b1, 8'h00, 8'h00}, 1'b1,
      '{2'd3, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 16'd0}},
    // First pass with a zero rise entry takes the fall entry.
    '{'{CMD_LOAD_RISE, 2'd1, 1'b1, 8'h10, 8'h00}, 1'b0, PREDICTED},
    '{'{CMD_LOAD_FALL, 2'd1, 1'b1, 8'h10, 8'h33}, 1'b0, PREDICTED},
    '{'{CMD_SAMPLE, 2'd1, 1'b1, 8'h10, 8'h00}, 1'b1,
      '{2'd1, 1'b1, 8'h33, 8'h33, 8'h10, 8'h10, 16'd0}},
    // Rise entry below the current level: no write.
    '{'{CMD_LOAD_RISE, 2'd1, 1'b1, 8'h40, 8'h20}, 1'b0, PREDICTED},
    '{'{CMD_LOAD_FALL, 2'd1, 1'b1, 8'h40, 8'h10}, 1'b0, PREDICTED},
    '{'{CMD_SAMPLE, 2'd1, 1'b1, 8'h40, 8'hFF}, 1'b0, PREDICTED},
    // Rise entry above the current level raises the duty.
    '{'{CMD_LOAD_RISE, 2'd1, 1'b1, 8'h80, 8'hC0}, 1'b0, PREDICTED},
    '{'{CMD_LOAD_FALL, 2'd1, 1'b1, 8'h80, 8'h90}, 1'b0, PREDICTED},
    '{'{CMD_SAMPLE, 2'd1, 1'b1, 8'h80, 8'h00}, 1'b0, PREDICTED},
    // Falling: lower only when the fall entry is below the level.
    '{'{CMD_SAMPLE, 2'd1, 1'b1, 8'h40, 8'h00}, 1'b0, PREDICTED},
    '{'{CMD_SAMPLE, 2'd1, 1'b1, 8'h10, 8'h00}, 1'b0, PREDICTED},
    // A failure resets the last temperature, so the next valid sample rises again.
    '{'{CMD_SAMPLE, 2'd1, 1'b0, 8'h80, 8'h00}, 1'b0, PREDICTED},
    '{'{CMD_SAMPLE, 2'd1, 1'b1, 8'h80, 8'h00}, 1'b0, PREDICTED},
    // Start clears the record, then samples.
    '{'{CMD_START, 2'd2, 1'b1, 8'hFF, 8'h00}, 1'b1,
      '{2'd2, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0}},
    '{'{CMD_START, 2'd1, 1'b0, 8'h40, 8'h00}, 1'b1,
      '{2'd1, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'd1}},
    '{'{CMD_LOAD_RISE, 2'd3, 1'b1, 8'h7F, 8'h00}, 1'b0, PREDICTED},
    '{'{CMD_LOAD_FALL, 2'd3, 1'b1, 8'h7F, 8'h44}, 1'b0, PREDICTED},
    '{'{CMD_SAMPLE, 2'd3, 1'b1, 8'h7F, 8'h00}, 1'b1,
      '{2'd3, 1'b1, 8'h44, 8'h44, 8'h7F, 8'h7F, 16'd0}},
    // A zero rise entry after the first pass is just a low entry: the duty holds.
    '{'{CMD_LOAD_RISE, 2'd3, 1'b1, 8'hFF, 8'h00}, 1'b0, PREDICTED},
    '{'{CMD_LOAD_FALL, 2'd3, 1'b1, 8'hFF, 8'h01}, 1'b0, PREDICTED},
    '{'{CMD_SAMPLE, 2'd3, 1'b1, 8'hFF, 8'h00}, 1'b0, PREDICTED}
  };

  logic clk;
  logic rst_n;

  fchc_in_if  in_ch ();
  fchc_out_if out_ch ();
  fchc_cfg_if cfg_ch ();

  fan_curve_hysteresis_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted copy of the block state: curve tables, per-fan records and the failure duty.
  logic [7:0]  rise_curve [TBL_DEPTH];
  logic [7:0]  fall_curve [TBL_DEPTH];
  logic [7:0]  rec_last_temp [FAN_COUNT];
  logic [7:0]  rec_level [FAN_COUNT];
  logic [7:0]  rec_min [FAN_COUNT];
  logic [7:0]  rec_max [FAN_COUNT];
  logic [15:0] rec_errors [FAN_COUNT];
  logic [7:0]  fail_duty;

  // Results still owed by the block, oldest first.
  fan_report_t pending_responses [$];
  int mismatch_count;

  // Stimulus side: which curve entries have been loaded, and each fan's temperature walk.
  bit         rise_written [FAN_COUNT][TEMP_STEPS];
  bit         fall_written [FAN_COUNT][TEMP_STEPS];
  logic [7:0] walk_temp [FAN_COUNT];
  int         items_sent;
  int         idle_pct;
  int         stall_pct;

  // Typed expectation of the directed row currently on the bus, if any.
  logic        row_typed;
  fan_report_t row_report;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver decides at each falling edge whether to take a result at the next edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void clear_fan_record(input int f);
    rec_last_temp[f] = 8'h00;
    rec_level[f]     = 8'h00;
    rec_min[f]       = TEMP_RESET_MIN;
    rec_max[f]       = 8'h00;
    rec_errors[f]    = 16'h0000;
  endfunction

  // Applies one command to the predicted state and returns the result it must produce.
  function automatic fan_report_t predict_fan_response(input fan_cmd_t op);
    fan_report_t r;
    int          f;
    int          slot;
    logic [7:0]  d;
    r = '0;
    r.fan_out = op.fan;
    f = int'(op.fan);
    if (f >= FAN_COUNT) return r;
    if (op.command == CMD_LOAD_RISE || op.command == CMD_LOAD_FALL) begin
      // Loads only touch the table; an index past the table is dropped.
      if (int'(op.temperature) < TEMP_STEPS) begin
        slot = f * TEMP_STEPS + int'(op.temperature);
        if (op.command == CMD_LOAD_RISE) rise_curve[slot] = op.entry_value;
        else fall_curve[slot] = op.entry_value;
      end
    end else begin
      // Lookups saturate at the last entry; comparisons use the raw reading.
      slot = f * TEMP_STEPS +
             ((int'(op.temperature) < TEMP_STEPS) ? int'(op.temperature) : TEMP_STEPS - 1);
      if (op.command == CMD_START) clear_fan_record(f);
      if (!op.sensor_ok) begin
        r.duty_write = 1'b1;
        r.duty = fail_duty;
        rec_last_temp[f] = 8'h00;
        if (rec_errors[f] != ERR_MAX) rec_errors[f] = rec_errors[f] + 16'd1;
      end else if (op.temperature != rec_last_temp[f]) begin
        if (op.temperature > rec_last_temp[f]) begin
          d = rise_curve[slot];
          if (d == 8'h00 && rec_last_temp[f] == 8'h00) begin
            // First pass with no rise entry: the fall curve sets the level outright.
            d = fall_curve[slot];
            r.duty_write = 1'b1;
            r.duty = d;
            rec_level[f] = d;
          end else if (d > rec_level[f]) begin
            r.duty_write = 1'b1;
            r.duty = d;
            rec_level[f] = d;
          end
        end else begin
          d = fall_curve[slot];
          if (d < rec_level[f]) begin
            r.duty_write = 1'b1;
            r.duty = d;
            rec_level[f] = d;
          end
        end
        rec_last_temp[f] = op.temperature;
        if (op.temperature > rec_max[f]) rec_max[f] = op.temperature;
        if (op.temperature < rec_min[f]) rec_min[f] = op.temperature;
      end
    end
    r.current_level = rec_level[f];
    r.min_temp      = rec_min[f];
    r.max_temp      = rec_max[f];
    r.error_total   = rec_errors[f];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] expected,
                             input logic [15:0] actual);
    if (actual !== expected) begin
      mismatch_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, expected, actual);
    end
  endtask

  // Everything is sampled at the rising edge, before the block's registers update.
  // A result is matched before a new command is predicted, so a spurious result can
  // never be paired with the expectation of a command accepted at the same edge.
  always @(posedge clk) begin : response_monitor
    fan_report_t seen;
    fan_report_t want;
    fan_cmd_t    op;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.fan_out, out_ch.duty_write, out_ch.duty, out_ch.current_level,
                 out_ch.min_temp, out_ch.max_temp, out_ch.error_total};
        if (pending_responses.size() == 0) begin
          mismatch_count++;
          $error("result transaction for fan %0d with no result pending", seen.fan_out);
        end else begin
          want = pending_responses.pop_front();
          check_field("fan_out", 16'(want.fan_out), 16'(seen.fan_out));
          check_field("duty_write", 16'(want.duty_write), 16'(seen.duty_write));
          check_field("duty", 16'(want.duty), 16'(seen.duty));
          check_field("current_level", 16'(want.current_level), 16'(seen.current_level));
          check_field("min_temp", 16'(want.min_temp), 16'(seen.min_temp));
          check_field("max_temp", 16'(want.max_temp), 16'(seen.max_temp));
          check_field("error_total", want.error_total, seen.error_total);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        op = '{cmd_t'(in_ch.command), in_ch.fan, in_ch.sensor_ok, in_ch.temperature,
               in_ch.entry_value};
        // The predictor runs on typed rows too, so its state stays in step.
        want = predict_fan_response(op);
        pending_responses.push_back(row_typed ? row_report : want);
      end
      if (cfg_ch.valid && cfg_ch.ready) fail_duty = cfg_ch.data;
    end
  end

  // Presents one command transaction and returns at the falling edge after it was taken.
  // Called at a falling edge. Valid stays high between back-to-back transactions.
  task automatic send_op(input fan_cmd_t op, input logic typed, input fan_report_t report);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= op.command;
    in_ch.fan         <= op.fan;
    in_ch.sensor_ok   <= op.sensor_ok;
    in_ch.temperature <= op.temperature;
    in_ch.entry_value <= op.entry_value;
    row_typed  = typed;
    row_report = report;
    if (int'(op.temperature) < TEMP_STEPS && int'(op.fan) < FAN_COUNT) begin
      if (op.command == CMD_LOAD_RISE) rise_written[op.fan][op.temperature] = 1'b1;
      if (op.command == CMD_LOAD_FALL) fall_written[op.fan][op.temperature] = 1'b1;
    end
    items_sent++;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every owed result has come back, plus a short margin
  // so the two-stage pipeline is certainly empty.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only used while the block is idle.
  task automatic write_max_duty(input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Curve values: some zero rise entries to hit the first-pass rule, some fully random,
  // and the rest close to the temperature so the curves look like real fan curves.
  function automatic logic [7:0] pick_curve_value(input bit rising, input logic [7:0] t);
    int v;
    if (rising && $urandom_range(5) == 0) return 8'h00;
    if ($urandom_range(1) == 1) return 8'($urandom);
    v = int'(t) + (rising ? int'($urandom_range(48)) : -int'($urandom_range(48)));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Unloaded curve entries must never be looked up, so every sample is preceded by
  // loads of whatever its fan and temperature still lack.
  task automatic load_missing_entries(input logic [1:0] fan, input logic [7:0] t);
    fan_cmd_t op;
    op.fan = fan;
    op.sensor_ok = 1'($urandom);
    op.temperature = t;
    if (!rise_written[fan][t]) begin
      op.command = CMD_LOAD_RISE;
      op.entry_value = pick_curve_value(1'b1, t);
      send_op(op, 1'b0, PREDICTED);
    end
    if (!fall_written[fan][t]) begin
      op.command = CMD_LOAD_FALL;
      op.entry_value = pick_curve_value(1'b0, t);
      send_op(op, 1'b0, PREDICTED);
    end
  endtask

  // Mostly samples that wander up and down around each fan's last temperature, which is
  // what exercises the hysteresis; some jumps, repeats, failures, starts and stray loads.
  task automatic issue_random_op();
    fan_cmd_t op;
    int       f;
    int       t;
    f = $urandom_range(FAN_COUNT - 1);
    op.fan = 2'(f);
    if ($urandom_range(99) < 10) begin
      op.command = ($urandom_range(1) == 1) ? CMD_LOAD_RISE : CMD_LOAD_FALL;
      op.sensor_ok = 1'($urandom);
      op.temperature = 8'($urandom);
      op.entry_value = pick_curve_value(op.command == CMD_LOAD_RISE, op.temperature);
      send_op(op, 1'b0, PREDICTED);
      return;
    end
    case ($urandom_range(9))
      0: t = $urandom_range(255);
      1: t = int'(walk_temp[f]);
      default: begin
        t = int'(walk_temp[f]) + int'($urandom_range(24)) - 12;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
      end
    endcase
    walk_temp[f] = 8'(t);
    load_missing_entries(op.fan, 8'(t));
    op.command = ($urandom_range(19) == 0) ? CMD_START : CMD_SAMPLE;
    op.sensor_ok = ($urandom_range(9) != 0);
    op.temperature = 8'(t);
    op.entry_value = 8'($urandom);
    send_op(op, 1'b0, PREDICTED);
  endtask

  initial begin : stimulus
    int       phase_start;
    bit       paused;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_SAMPLE;
    in_ch.fan = 2'd0;
    in_ch.sensor_ok = 1'b0;
    in_ch.temperature = 8'h00;
    in_ch.entry_value = 8'h00;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 8'h00;
    row_typed = 1'b0;
    row_report = '0;
    mismatch_count = 0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    fail_duty = 8'hFF;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      rise_curve[i] = 8'h00;
      fall_curve[i] = 8'h00;
    end
    for (int f = 0; f < FAN_COUNT; f++) begin
      clear_fan_record(f);
      walk_temp[f] = 8'h00;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed script at full rate, on the reset value of max_duty.
    foreach (SCRIPT[i]) send_op(SCRIPT[i].op, SCRIPT[i].typed, SCRIPT[i].report);
    wait_until_drained();

    // Random phases, each with its own flow-control mix and failure duty. Halfway
    // through each, the sender holds off until the block has returned every result.
    for (int p = 0; p < 4; p++) begin
      idle_pct = SRC_IDLE_PCT[p];
      stall_pct = SNK_STALL_PCT[p];
      case (p)
        0: write_max_duty(8'h00);
        1: write_max_duty(8'hFF);
        2: write_max_duty(8'($urandom));
        default: write_max_duty(8'h01);
      endcase
      phase_start = items_sent;
      paused = 1'b0;
      while (items_sent - phase_start < RANDOM_ITEMS_PER_PHASE) begin
        if (!paused && items_sent - phase_start >= RANDOM_ITEMS_PER_PHASE / 2) begin
          wait_until_drained();
          paused = 1'b1;
        end
        issue_random_op();
      end
      wait_until_drained();
    end

    // Trailing window: any extra result the block still emits is caught here.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("tb_fan_curve_hysteresis_controller passed");
    end else begin
      $display("tb_fan_curve_hysteresis_controller failed");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin : watchdog
    #5_000_000;
    $display("tb_fan_curve_hysteresis_controller failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/fchc_pkg.sv
rtl/core/fchc_ifs.sv
rtl/core/fchc_ram.sv
rtl/core/fchc_update.sv
rtl/core/fan_curve_hysteresis_controller.sv
dv/tb_fan_curve_hysteresis_controller.sv
